>>> hdl/obstacle_avoidance_sequencer_core_assert.svh
// Assertion macros for the obstacle avoidance sequencer core.
// No dependencies; included by the top level at its end.
`ifndef OBSTACLE_AVOIDANCE_SEQUENCER_CORE_ASSERT_SVH
`define OBSTACLE_AVOIDANCE_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTH
`define OAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("oas assertion failed");
`define OAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("oas assertion failed");
`else
`define OAS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/oas_pkg.sv
// Shared types and constants of the obstacle avoidance sequencer.
// No dependencies; used by every module of the block.
`default_nettype none
package oas_pkg;

	localparam int TIMER_BITS_DEF = 20;
	localparam int DIST_BITS_DEF  = 12;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;

	localparam int SIDE_TOO_CLOSE_RST = 100;
	localparam int FWD_DURATION_RST   = 1000;
	localparam int IR_CLEAR_RST       = 200;
	localparam int SONAR_CLEAR_RST    = 200;
	localparam int PORT_WALL_RST      = 150;
	localparam int STAR_WALL_RST      = 150;
	localparam int SONAR_WALL_RST     = 150;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE_TOO_CLOSE = 3'd0,
		REG_FWD_DURATION   = 3'd1,
		REG_IR_CLEAR       = 3'd2,
		REG_SONAR_CLEAR    = 3'd3,
		REG_PORT_WALL      = 3'd4,
		REG_STAR_WALL      = 3'd5,
		REG_SONAR_WALL     = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_STRAFE  = 2'd1,
		PH_FORWARD = 2'd2,
		PH_RECOVER = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		MOT_NONE  = 3'd0,
		MOT_STOP  = 3'd1,
		MOT_FWD   = 3'd2,
		MOT_LEFT  = 3'd3,
		MOT_RIGHT = 3'd4
	} motor_t;

	typedef enum logic [2:0] {
		EXIT_IDLE   = 3'd0,
		EXIT_BUSY   = 3'd1,
		EXIT_FIRE   = 3'd2,
		EXIT_NOROOM = 3'd3,
		EXIT_WALL   = 3'd4,
		EXIT_DONE   = 3'd5
	} exit_t;

	typedef struct packed {
		motor_t motor;
		exit_t  code;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/oas_cfg_regs.sv
// Configuration register file of the obstacle avoidance sequencer.
// Depends on oas_pkg for register indexes and reset values.
`default_nettype none
module oas_cfg_regs #(
	parameter int TIMER_BITS = oas_pkg::TIMER_BITS_DEF,
	parameter int DIST_BITS  = oas_pkg::DIST_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [oas_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [oas_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic      [DIST_BITS-1:0]            side_too_close_mm,
	output logic      [TIMER_BITS-1:0]           forward_duration_ms,
	output logic      [DIST_BITS-1:0]            ir_clear_mm,
	output logic      [DIST_BITS-1:0]            sonar_clear_mm,
	output logic      [DIST_BITS-1:0]            port_wall_mm,
	output logic      [DIST_BITS-1:0]            star_wall_mm,
	output logic      [DIST_BITS-1:0]            sonar_wall_mm
);

	logic [DIST_BITS-1:0] dist_data;

	assign dist_data = wr_data[DIST_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_too_close_mm   <= DIST_BITS'(oas_pkg::SIDE_TOO_CLOSE_RST);
			forward_duration_ms <= TIMER_BITS'(oas_pkg::FWD_DURATION_RST);
			ir_clear_mm         <= DIST_BITS'(oas_pkg::IR_CLEAR_RST);
			sonar_clear_mm      <= DIST_BITS'(oas_pkg::SONAR_CLEAR_RST);
			port_wall_mm        <= DIST_BITS'(oas_pkg::PORT_WALL_RST);
			star_wall_mm        <= DIST_BITS'(oas_pkg::STAR_WALL_RST);
			sonar_wall_mm       <= DIST_BITS'(oas_pkg::SONAR_WALL_RST);
		end else if (wr_en) begin
			case (wr_index)
				oas_pkg::REG_SIDE_TOO_CLOSE: side_too_close_mm   <= dist_data;
				oas_pkg::REG_FWD_DURATION:   forward_duration_ms <= wr_data[TIMER_BITS-1:0];
				oas_pkg::REG_IR_CLEAR:       ir_clear_mm         <= dist_data;
				oas_pkg::REG_SONAR_CLEAR:    sonar_clear_mm      <= dist_data;
				oas_pkg::REG_PORT_WALL:      port_wall_mm        <= dist_data;
				oas_pkg::REG_STAR_WALL:      star_wall_mm        <= dist_data;
				oas_pkg::REG_SONAR_WALL:     sonar_wall_mm       <= dist_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/oas_seq.sv
// Sequencer state and single-pass step logic: phase, direction, timers.
// Depends on oas_pkg for phase, motor and exit codes.
`default_nettype none
module oas_seq #(
	parameter int TIMER_BITS = oas_pkg::TIMER_BITS_DEF,
	parameter int DIST_BITS  = oas_pkg::DIST_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire logic                    mode,
	input  wire logic                    fire_seen,
	input  wire logic [DIST_BITS-1:0]    port_bow_mm,
	input  wire logic [DIST_BITS-1:0]    star_bow_mm,
	input  wire logic [DIST_BITS-1:0]    port_side_mm,
	input  wire logic [DIST_BITS-1:0]    star_side_mm,
	input  wire logic [DIST_BITS-1:0]    sonar_mm,
	input  wire logic                    sonar_ok,
	input  wire logic [DIST_BITS-1:0]    side_too_close_mm,
	input  wire logic [TIMER_BITS-1:0]   forward_duration_ms,
	input  wire logic [DIST_BITS-1:0]    ir_clear_mm,
	input  wire logic [DIST_BITS-1:0]    sonar_clear_mm,
	input  wire logic [DIST_BITS-1:0]    port_wall_mm,
	input  wire logic [DIST_BITS-1:0]    star_wall_mm,
	input  wire logic [DIST_BITS-1:0]    sonar_wall_mm,
	output oas_pkg::result_t             res,
	output oas_pkg::phase_t              phase
);

	oas_pkg::phase_t        phase_q, phase_d;
	logic                   dir_right_q, dir_right_d;
	logic [TIMER_BITS-1:0]  elapsed_q, elapsed_d, elapsed_inc;
	logic [TIMER_BITS-1:0]  strafe_len_q, strafe_len_d;
	logic [DIST_BITS-1:0]   sonar_eff, recov_ir;
	logic                   no_room, still_blocked, wall_seen;

	assign sonar_eff     = sonar_ok ? sonar_mm : '0;
	assign recov_ir      = dir_right_q ? port_bow_mm : star_bow_mm;
	assign elapsed_inc   = (&elapsed_q) ? elapsed_q : elapsed_q + TIMER_BITS'(1);
	assign no_room       = (port_side_mm < side_too_close_mm) ||
	                       (star_side_mm < side_too_close_mm);
	assign still_blocked = (recov_ir < ir_clear_mm) || (sonar_eff < sonar_clear_mm);
	assign wall_seen     = (port_bow_mm < port_wall_mm) && (star_bow_mm < star_wall_mm) &&
	                       (sonar_eff < sonar_wall_mm);
	assign phase         = phase_q;

	always_comb begin
		res.motor    = oas_pkg::MOT_NONE;
		res.code     = oas_pkg::EXIT_BUSY;
		phase_d      = phase_q;
		dir_right_d  = dir_right_q;
		elapsed_d    = elapsed_q;
		strafe_len_d = strafe_len_q;
		if (mode) begin
			if (fire_seen) begin
				phase_d  = oas_pkg::PH_IDLE;
				res.code = oas_pkg::EXIT_FIRE;
			end else begin
				if (port_bow_mm < star_bow_mm) begin
					dir_right_d = 1'b1;
					res.motor   = oas_pkg::MOT_RIGHT;
				end else begin
					dir_right_d = 1'b0;
					res.motor   = oas_pkg::MOT_LEFT;
				end
				elapsed_d = '0;
				phase_d   = oas_pkg::PH_STRAFE;
			end
		end else begin
			elapsed_d = elapsed_inc;
			case (phase_q)
				oas_pkg::PH_STRAFE: begin
					if (no_room) begin
						res.motor = oas_pkg::MOT_STOP;
						res.code  = oas_pkg::EXIT_NOROOM;
						phase_d   = oas_pkg::PH_IDLE;
					end else if (!still_blocked) begin
						strafe_len_d = elapsed_inc;
						elapsed_d    = '0;
						res.motor    = oas_pkg::MOT_FWD;
						phase_d      = oas_pkg::PH_FORWARD;
					end
				end
				oas_pkg::PH_FORWARD: begin
					if (wall_seen) begin
						res.code = oas_pkg::EXIT_WALL;
						phase_d  = oas_pkg::PH_IDLE;
					end else if (elapsed_inc > forward_duration_ms) begin
						res.motor = dir_right_q ? oas_pkg::MOT_LEFT : oas_pkg::MOT_RIGHT;
						elapsed_d = '0;
						phase_d   = oas_pkg::PH_RECOVER;
					end
				end
				oas_pkg::PH_RECOVER: begin
					if (elapsed_inc >= strafe_len_q) begin
						res.motor = oas_pkg::MOT_FWD;
						res.code  = oas_pkg::EXIT_DONE;
						phase_d   = oas_pkg::PH_IDLE;
					end
				end
				oas_pkg::PH_IDLE: res.code = oas_pkg::EXIT_IDLE;
				default:          res.code = oas_pkg::EXIT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= oas_pkg::PH_IDLE;
			dir_right_q  <= 1'b0;
			elapsed_q    <= '0;
			strafe_len_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			dir_right_q  <= dir_right_d;
			elapsed_q    <= elapsed_d;
			strafe_len_q <= strafe_len_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/obstacle_avoidance_sequencer_core.sv
// Top level of the obstacle avoidance sequencer: input and result registers.
// Depends on oas_pkg, oas_cfg_regs, oas_seq and the assertion header.
//
//   channel | handshake          | word
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_stall  | mode, fire_seen, five distances, sonar_ok
//   out     | out_valid/out_stall| motor_cmd, exit_code
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per clock sustained while out_stall is low; a word passes the input register, then the result register.
// The step logic between the input register and the result register is combinational.
// Reset clears the valid flags and sequencer state and loads the configuration defaults; cfg_ready stays high.
// A stalled result holds; the input register still takes one more word behind it.
`default_nettype none
module obstacle_avoidance_sequencer_core #(
	parameter int TIMER_BITS = oas_pkg::TIMER_BITS_DEF,
	parameter int DIST_BITS  = oas_pkg::DIST_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            mode,
	input  wire logic                            fire_seen,
	input  wire logic [DIST_BITS-1:0]            port_bow_mm,
	input  wire logic [DIST_BITS-1:0]            star_bow_mm,
	input  wire logic [DIST_BITS-1:0]            port_side_mm,
	input  wire logic [DIST_BITS-1:0]            star_side_mm,
	input  wire logic [DIST_BITS-1:0]            sonar_mm,
	input  wire logic                            sonar_ok,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [2:0]                      motor_cmd,
	output logic      [2:0]                      exit_code,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [oas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [oas_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                   valid_s1;
	logic                   mode_s1, fire_s1, sonar_ok_s1;
	logic [DIST_BITS-1:0]   port_bow_s1, star_bow_s1, port_side_s1, star_side_s1, sonar_s1;
	logic                   valid_s2;
	oas_pkg::result_t       res_s2, res_d;
	oas_pkg::phase_t        phase;
	logic                   s2_free, adv_s1, load_s1;
	logic [DIST_BITS-1:0]   side_too_close_mm, ir_clear_mm, sonar_clear_mm;
	logic [DIST_BITS-1:0]   port_wall_mm, star_wall_mm, sonar_wall_mm;
	logic [TIMER_BITS-1:0]  forward_duration_ms;

	assign s2_free   = !valid_s2 || !out_stall;
	assign adv_s1    = valid_s1 && s2_free;
	assign load_s1   = !valid_s1 || adv_s1;
	assign in_stall  = !load_s1;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign motor_cmd = res_s2.motor;
	assign exit_code = res_s2.code;

	oas_cfg_regs #(
		.TIMER_BITS (TIMER_BITS),
		.DIST_BITS  (DIST_BITS)
	) u_cfg (
		.clk                 (clk),
		.arst_n              (arst_n),
		.wr_en               (cfg_valid && cfg_ready),
		.wr_index            (cfg_index),
		.wr_data             (cfg_data),
		.side_too_close_mm   (side_too_close_mm),
		.forward_duration_ms (forward_duration_ms),
		.ir_clear_mm         (ir_clear_mm),
		.sonar_clear_mm      (sonar_clear_mm),
		.port_wall_mm        (port_wall_mm),
		.star_wall_mm        (star_wall_mm),
		.sonar_wall_mm       (sonar_wall_mm)
	);

	oas_seq #(
		.TIMER_BITS (TIMER_BITS),
		.DIST_BITS  (DIST_BITS)
	) u_seq (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (adv_s1),
		.mode                (mode_s1),
		.fire_seen           (fire_s1),
		.port_bow_mm         (port_bow_s1),
		.star_bow_mm         (star_bow_s1),
		.port_side_mm        (port_side_s1),
		.star_side_mm        (star_side_s1),
		.sonar_mm            (sonar_s1),
		.sonar_ok            (sonar_ok_s1),
		.side_too_close_mm   (side_too_close_mm),
		.forward_duration_ms (forward_duration_ms),
		.ir_clear_mm         (ir_clear_mm),
		.sonar_clear_mm      (sonar_clear_mm),
		.port_wall_mm        (port_wall_mm),
		.star_wall_mm        (star_wall_mm),
		.sonar_wall_mm       (sonar_wall_mm),
		.res                 (res_d),
		.phase               (phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			mode_s1      <= mode;
			fire_s1      <= fire_seen;
			port_bow_s1  <= port_bow_mm;
			star_bow_s1  <= star_bow_mm;
			port_side_s1 <= port_side_mm;
			star_side_s1 <= star_side_mm;
			sonar_s1     <= sonar_mm;
			sonar_ok_s1  <= sonar_ok;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	`include "obstacle_avoidance_sequencer_core_assert.svh"

	`OAS_ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv_s1, valid_s2)
	`OAS_ASSERT_NOW(a_idle_tick_quiet, clk, arst_n, adv_s1 && !mode_s1 && phase == oas_pkg::PH_IDLE, res_d.code == oas_pkg::EXIT_IDLE && res_d.motor == oas_pkg::MOT_NONE)
	`OAS_ASSERT_NEXT(a_exit_to_idle, clk, arst_n, adv_s1 && (res_d.code == oas_pkg::EXIT_FIRE || res_d.code == oas_pkg::EXIT_NOROOM || res_d.code == oas_pkg::EXIT_WALL || res_d.code == oas_pkg::EXIT_DONE), phase == oas_pkg::PH_IDLE)

endmodule
`default_nettype wire

>>> sim/tb_obstacle_avoidance_sequencer_core.sv
`timescale 1ns / 100ps
// Testbench for obstacle_avoidance_sequencer_core: random and directed sensor words,
// predicted motor command and exit code checked word by word on the result channel.
// Depends on oas_pkg and the core RTL only.
module tb_obstacle_avoidance_sequencer_core;

	localparam int DIST_W = oas_pkg::DIST_BITS_DEF;
	localparam int TIMER_W = oas_pkg::TIMER_BITS_DEF;
	localparam int FWD_W = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [oas_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int MM_MAX = (1 << DIST_W) - 1;

	typedef struct packed {
		logic              mode;
		logic              fire;
		logic [DIST_W-1:0] pbow;
		logic [DIST_W-1:0] sbow;
		logic [DIST_W-1:0] pside;
		logic [DIST_W-1:0] sside;
		logic [DIST_W-1:0] sonar;
		logic              sonar_ok;
		logic              drain;
	} sensor_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [oas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [oas_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	sensor_word_t sent_word = '0;

	wire in_stall, out_valid, cfg_ready;
	wire [2:0] motor_cmd, exit_code;
	wire mode = sent_word.mode;
	wire fire_seen = sent_word.fire;
	wire [DIST_W-1:0] port_bow_mm = sent_word.pbow;
	wire [DIST_W-1:0] star_bow_mm = sent_word.sbow;
	wire [DIST_W-1:0] port_side_mm = sent_word.pside;
	wire [DIST_W-1:0] star_side_mm = sent_word.sside;
	wire [DIST_W-1:0] sonar_mm = sent_word.sonar;
	wire sonar_ok = sent_word.sonar_ok;

	// register copies
	logic [DIST_W-1:0] cfg_side_mm = DIST_W'(oas_pkg::SIDE_TOO_CLOSE_RST);
	logic [FWD_W-1:0] cfg_fwd_ms = FWD_W'(oas_pkg::FWD_DURATION_RST);
	logic [DIST_W-1:0] cfg_ir_clear = DIST_W'(oas_pkg::IR_CLEAR_RST);
	logic [DIST_W-1:0] cfg_sonar_clear = DIST_W'(oas_pkg::SONAR_CLEAR_RST);
	logic [DIST_W-1:0] cfg_port_wall = DIST_W'(oas_pkg::PORT_WALL_RST);
	logic [DIST_W-1:0] cfg_star_wall = DIST_W'(oas_pkg::STAR_WALL_RST);
	logic [DIST_W-1:0] cfg_sonar_wall = DIST_W'(oas_pkg::SONAR_WALL_RST);

	// manoeuvre state
	oas_pkg::phase_t seq_phase;
	logic dir_right;
	logic [TIMER_W-1:0] elapsed_ms;
	logic [TIMER_W-1:0] strafe_len_ms;

	sensor_word_t sensor_words[$];
	oas_pkg::result_t motor_exit_q[$];
	int words_queued = 0;
	int words_taken = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_left = 0;
	logic [2:0] stall_pos = '0;
	logic [7:0] stall_mask = '0;

	obstacle_avoidance_sequencer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.fire_seen(fire_seen),
		.port_bow_mm(port_bow_mm),
		.star_bow_mm(star_bow_mm),
		.port_side_mm(port_side_mm),
		.star_side_mm(star_side_mm),
		.sonar_mm(sonar_mm),
		.sonar_ok(sonar_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.motor_cmd(motor_cmd),
		.exit_code(exit_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic oas_pkg::result_t step_avoidance(sensor_word_t w);
		logic [DIST_W-1:0] sonar;
		logic [DIST_W-1:0] ir;
		oas_pkg::result_t r;
		sonar = w.sonar_ok ? w.sonar : '0;
		r.motor = oas_pkg::MOT_NONE;
		r.code = oas_pkg::EXIT_BUSY;
		if (w.mode) begin
			if (w.fire) begin
				seq_phase = oas_pkg::PH_IDLE;
				r.code = oas_pkg::EXIT_FIRE;
			end else begin
				dir_right = (w.pbow < w.sbow);
				if (dir_right) r.motor = oas_pkg::MOT_RIGHT;
				else r.motor = oas_pkg::MOT_LEFT;
				elapsed_ms = '0;
				seq_phase = oas_pkg::PH_STRAFE;
			end
		end else begin
			if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
			case (seq_phase)
				oas_pkg::PH_STRAFE: begin
					ir = dir_right ? w.pbow : w.sbow;
					if (w.pside < cfg_side_mm || w.sside < cfg_side_mm) begin
						r.motor = oas_pkg::MOT_STOP;
						r.code = oas_pkg::EXIT_NOROOM;
						seq_phase = oas_pkg::PH_IDLE;
					end else if (!(ir < cfg_ir_clear || sonar < cfg_sonar_clear)) begin
						strafe_len_ms = elapsed_ms;
						elapsed_ms = '0;
						r.motor = oas_pkg::MOT_FWD;
						seq_phase = oas_pkg::PH_FORWARD;
					end
				end
				oas_pkg::PH_FORWARD: begin
					if (w.pbow < cfg_port_wall && w.sbow < cfg_star_wall &&
							sonar < cfg_sonar_wall) begin
						r.code = oas_pkg::EXIT_WALL;
						seq_phase = oas_pkg::PH_IDLE;
					end else if (elapsed_ms > cfg_fwd_ms) begin
						if (dir_right) r.motor = oas_pkg::MOT_LEFT;
						else r.motor = oas_pkg::MOT_RIGHT;
						elapsed_ms = '0;
						seq_phase = oas_pkg::PH_RECOVER;
					end
				end
				oas_pkg::PH_RECOVER: begin
					if (elapsed_ms >= strafe_len_ms) begin
						r.motor = oas_pkg::MOT_FWD;
						r.code = oas_pkg::EXIT_DONE;
						seq_phase = oas_pkg::PH_IDLE;
					end
				end
				default: r.code = oas_pkg::EXIT_IDLE;
			endcase
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin : drive_words
		sensor_word_t nxt;
		logic hold;
		logic send;
		if (!arst_n) begin
			in_valid <= 1'b0;
			seq_phase = oas_pkg::PH_IDLE;
			dir_right = 1'b0;
			elapsed_ms = '0;
			strafe_len_ms = '0;
		end else begin
			hold = in_valid && in_stall;
			if (in_valid && !in_stall) begin
				motor_exit_q.push_back(step_avoidance(sent_word));
				words_taken++;
			end
			send = 1'b0;
			nxt = sent_word;
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sensor_words.size() > 0 &&
						!(sensor_words[0].drain && motor_exit_q.size() > 0)) begin
					nxt = sensor_words.pop_front();
					send = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(31, 0);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
					end
				end
				in_valid <= send;
				sent_word <= nxt;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : check_results
		oas_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (motor_exit_q.size() == 0) begin
					errors++;
					if (errors <= 200)
						$display("%0t: expected no result, actual motor_cmd %0d exit_code %0d",
							$time, motor_cmd, exit_code);
				end else begin
					want = motor_exit_q.pop_front();
					if (motor_cmd !== want.motor) begin
						errors++;
						if (errors <= 200)
							$display("%0t: motor_cmd expected %0d actual %0d",
								$time, want.motor, motor_cmd);
					end
					if (exit_code !== want.code) begin
						errors++;
						if (errors <= 200)
							$display("%0t: exit_code expected %0d actual %0d",
								$time, want.code, exit_code);
					end
				end
			end
			if (stall_left == 0) begin
				case ($urandom_range(3))
					0: stall_mask = 8'h00;
					1: stall_mask = 8'b1110_1110;
					default: stall_mask = 8'($urandom_range(255)) & 8'hFE;
				endcase
				stall_left = $urandom_range(96, 16);
			end else begin
				stall_left--;
			end
			stall_pos = stall_pos + 3'd1;
			out_stall <= stall_mask[stall_pos];
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL obstacle_avoidance_sequencer_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int rand_mm();
		return int'($urandom_range(MM_MAX, 0));
	endfunction

	function automatic int mm_from(logic [DIST_W-1:0] lo);
		return int'($urandom_range(MM_MAX, int'(lo)));
	endfunction

	function automatic int mm_under(logic [DIST_W-1:0] lo);
		return (lo > 0) ? int'($urandom_range(int'(lo) - 1, 0)) : 0;
	endfunction

	task automatic add_word(int m, int f, int pb, int sb, int ps, int ss, int so,
			int ok, int dr);
		sensor_word_t w;
		w = '{1'(m), 1'(f), DIST_W'(pb), DIST_W'(sb), DIST_W'(ps), DIST_W'(ss),
			DIST_W'(so), 1'(ok), 1'(dr)};
		sensor_words.push_back(w);
		words_queued++;
	endtask

	task automatic write_reg(logic [oas_pkg::CFG_IDX_W-1:0] idx, int val);
		logic [oas_pkg::CFG_DATA_W-1:0] data;
		data = $urandom_range(1) ? $urandom() : '0;
		if (idx == oas_pkg::REG_FWD_DURATION) data[FWD_W-1:0] = FWD_W'(val);
		else data[DIST_W-1:0] = DIST_W'(val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			oas_pkg::REG_SIDE_TOO_CLOSE: cfg_side_mm = data[DIST_W-1:0];
			oas_pkg::REG_FWD_DURATION:   cfg_fwd_ms = data[FWD_W-1:0];
			oas_pkg::REG_IR_CLEAR:       cfg_ir_clear = data[DIST_W-1:0];
			oas_pkg::REG_SONAR_CLEAR:    cfg_sonar_clear = data[DIST_W-1:0];
			oas_pkg::REG_PORT_WALL:      cfg_port_wall = data[DIST_W-1:0];
			oas_pkg::REG_STAR_WALL:      cfg_star_wall = data[DIST_W-1:0];
			oas_pkg::REG_SONAR_WALL:     cfg_sonar_wall = data[DIST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(int side, int fwd, int irc, int snc, int pw, int sw, int sow);
		write_reg(oas_pkg::REG_SIDE_TOO_CLOSE, side);
		write_reg(oas_pkg::REG_FWD_DURATION, fwd);
		write_reg(oas_pkg::REG_IR_CLEAR, irc);
		write_reg(oas_pkg::REG_SONAR_CLEAR, snc);
		write_reg(oas_pkg::REG_PORT_WALL, pw);
		write_reg(oas_pkg::REG_STAR_WALL, sw);
		write_reg(oas_pkg::REG_SONAR_WALL, sow);
		if ($urandom_range(1)) write_reg(REG_UNUSED, int'($urandom()));
	endtask

	// wait for every result, then let the pipeline empty
	task automatic settle();
		do @(posedge clk); while (words_taken != words_queued || motor_exit_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic gen_manoeuvre();
		int n_strafe, n_fwd, n_rec, n_extra, wall_at, k;
		int pb, sb;
		int dr;
		dr = ($urandom_range(19) == 0) ? 1 : 0;
		if ($urandom_range(9) == 0) begin
			add_word($urandom_range(1), $urandom_range(1), rand_mm(), rand_mm(), rand_mm(),
				rand_mm(), rand_mm(), $urandom_range(1), dr);
			return;
		end
		pb = rand_mm();
		sb = ($urandom_range(7) == 0) ? pb : rand_mm();
		if ($urandom_range(9) == 0) begin
			add_word(1, 1, pb, sb, rand_mm(), rand_mm(), rand_mm(), $urandom_range(1), dr);
			return;
		end
		add_word(1, 0, pb, sb, rand_mm(), rand_mm(), rand_mm(), $urandom_range(1), dr);
		n_strafe = $urandom_range(5, 0);
		for (k = 0; k < n_strafe; k++) begin
			case ($urandom_range(2))
				0: add_word(0, $urandom_range(1), mm_under(cfg_ir_clear),
					mm_under(cfg_ir_clear), mm_from(cfg_side_mm), mm_from(cfg_side_mm),
					rand_mm(), $urandom_range(1), 0);
				1: add_word(0, $urandom_range(1), rand_mm(), rand_mm(), mm_from(cfg_side_mm),
					mm_from(cfg_side_mm), mm_under(cfg_sonar_clear), 1, 0);
				default: add_word(0, $urandom_range(1), rand_mm(), rand_mm(),
					mm_from(cfg_side_mm), mm_from(cfg_side_mm), rand_mm(), 0, 0);
			endcase
		end
		if ($urandom_range(7) == 0) begin
			if ($urandom_range(1))
				add_word(0, $urandom_range(1), rand_mm(), rand_mm(), mm_under(cfg_side_mm),
					rand_mm(), rand_mm(), $urandom_range(1), 0);
			else
				add_word(0, $urandom_range(1), rand_mm(), rand_mm(), rand_mm(),
					mm_under(cfg_side_mm), rand_mm(), $urandom_range(1), 0);
			return;
		end
		add_word(0, $urandom_range(1), mm_from(cfg_ir_clear), mm_from(cfg_ir_clear),
			mm_from(cfg_side_mm), mm_from(cfg_side_mm), mm_from(cfg_sonar_clear), 1, 0);
		n_fwd = (cfg_fwd_ms <= 12) ? int'(cfg_fwd_ms) + 1 : int'($urandom_range(8, 1));
		wall_at = ($urandom_range(7) == 0) ? int'($urandom_range(n_fwd, 1)) : 0;
		for (k = 1; k <= n_fwd; k++) begin
			if (k == wall_at) begin
				add_word(0, $urandom_range(1), mm_under(cfg_port_wall),
					mm_under(cfg_star_wall), rand_mm(), rand_mm(), mm_under(cfg_sonar_wall),
					1, 0);
				return;
			end
			case ($urandom_range(2))
				0: add_word(0, $urandom_range(1), mm_from(cfg_port_wall), rand_mm(),
					rand_mm(), rand_mm(), rand_mm(), $urandom_range(1), 0);
				1: add_word(0, $urandom_range(1), rand_mm(), mm_from(cfg_star_wall),
					rand_mm(), rand_mm(), rand_mm(), $urandom_range(1), 0);
				default: add_word(0, $urandom_range(1), rand_mm(), rand_mm(), rand_mm(),
					rand_mm(), mm_from(cfg_sonar_wall), 1, 0);
			endcase
		end
		if (cfg_fwd_ms > 12) return;
		n_rec = ($urandom_range(5) == 0) ? int'($urandom_range(n_strafe, 0)) : n_strafe + 1;
		n_extra = $urandom_range(2, 0);
		for (k = 0; k < n_rec + n_extra; k++)
			add_word(0, $urandom_range(1), rand_mm(), rand_mm(), rand_mm(), rand_mm(),
				rand_mm(), $urandom_range(1), 0);
	endtask

	task automatic random_phase(int n);
		int goal;
		goal = words_queued + n;
		@(negedge clk);
		while (words_queued < goal) gen_manoeuvre();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_word(0, 1, MM_MAX, MM_MAX, MM_MAX, MM_MAX, MM_MAX, 1, 0);
		add_word(1, 1, MM_MAX, MM_MAX, MM_MAX, MM_MAX, MM_MAX, 1, 0);
		add_word(1, 0, 300, 300, 0, 0, 0, 0, 0);
		add_word(0, 0, MM_MAX, MM_MAX, 50, MM_MAX, MM_MAX, 1, 0);
		add_word(1, 0, 100, 101, 0, 0, 0, 0, 0);
		add_word(0, 0, 100, MM_MAX, MM_MAX, MM_MAX, MM_MAX, 1, 0);
		add_word(0, 0, MM_MAX, MM_MAX, MM_MAX, MM_MAX, MM_MAX, 0, 0);
		add_word(0, 0, MM_MAX, 0, 100, 100, 200, 1, 0);
		add_word(0, 0, 149, 149, MM_MAX, MM_MAX, 149, 1, 0);
		add_word(1, 0, MM_MAX, 0, 0, 0, 0, 0, 1);
		add_word(0, 0, 0, 200, 100, MM_MAX, MM_MAX, 1, 0);
		add_word(1, 0, 0, 1, 0, 0, 0, 0, 0);
		add_word(1, 1, 0, 0, 0, 0, 0, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
		settle();

		load_settings(100, 0, 200, 200, 150, 150, 150);
		@(negedge clk);
		add_word(1, 0, 300, 300, 0, 0, 0, 0, 0);
		add_word(0, 0, 300, MM_MAX, MM_MAX, MM_MAX, MM_MAX, 1, 0);
		add_word(0, 0, 0, 0, MM_MAX, MM_MAX, 0, 1, 0);
		add_word(1, 0, 10, 20, 0, 0, 0, 0, 0);
		add_word(0, 0, MM_MAX, 0, MM_MAX, MM_MAX, 300, 1, 0);
		add_word(0, 0, MM_MAX, 0, MM_MAX, MM_MAX, 0, 1, 0);
		add_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
		settle();

		load_settings(0, 0, 0, 0, 0, 0, 0);
		random_phase(200);
		settle();
		load_settings(MM_MAX, (1 << FWD_W) - 1, MM_MAX, MM_MAX, MM_MAX, MM_MAX, MM_MAX);
		random_phase(150);
		repeat (5) begin
			settle();
			load_settings($urandom_range(400, 0), $urandom_range(12, 0),
				$urandom_range(MM_MAX, 0), $urandom_range(MM_MAX, 0),
				$urandom_range(MM_MAX, 0), $urandom_range(MM_MAX, 0),
				$urandom_range(MM_MAX, 0));
			random_phase(220);
		end
		settle();

		if (errors == 0)
			$display("PASS obstacle_avoidance_sequencer_core");
		else
			$display("FAIL obstacle_avoidance_sequencer_core");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/oas_pkg.sv
hdl/oas_cfg_regs.sv
hdl/oas_seq.sv
hdl/obstacle_avoidance_sequencer_core.sv
sim/tb_obstacle_avoidance_sequencer_core.sv
